@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each check is gated by reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check.
`define DRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check.
`define DRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/drc_pkg.sv @@
package drc_pkg;

  localparam int MAP_SIDE_DEF      = 32;
  localparam int SCREEN_WIDTH_DEF  = 800;
  localparam int SCREEN_HEIGHT_DEF = 450;
  localparam int MAX_STEPS_DEF     = 64;

  localparam int CELL_W     = 8;
  localparam int COLOR_W    = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int MAP_ADDR_W = 16;

  localparam int DIV_NW = 32;
  localparam int DIV_DW = 48;

  localparam logic [CFG_IDX_W-1:0] REG_COLOR_TWO     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_THREE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_DEFAULT = 2'd2;

  localparam logic [COLOR_W-1:0] COLOR_TWO_RST     = 24'h00E430;
  localparam logic [COLOR_W-1:0] COLOR_THREE_RST   = 24'h0079F1;
  localparam logic [COLOR_W-1:0] COLOR_DEFAULT_RST = 24'hE62937;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  localparam logic [CELL_W-1:0] CELL_EMPTY = 8'd0;
  localparam logic [CELL_W-1:0] CELL_TWO   = 8'd2;
  localparam logic [CELL_W-1:0] CELL_THREE = 8'd3;

  localparam logic [DIV_DW-1:0] DIST_INF = 48'h0100_0000_0000;
  localparam logic [23:0]       FOG_CAP  = 24'hFF_FFFF;
  // floor(x / 10) for any 32-bit x as (x * FOG_RECIP) >> FOG_SH
  localparam logic [31:0]       FOG_RECIP = 32'hCCCC_CCCD;
  localparam int                FOG_SH    = 35;
  localparam logic [DIV_NW-1:0] ONE_Q30  = 32'h4000_0000;

  typedef struct packed {
    logic                  we;
    logic                  re;
    logic [MAP_ADDR_W-1:0] addr;
    logic [CELL_W-1:0]     wdata;
  } map_req_t;

endpackage

@@ design/drc_if.sv @@
interface drc_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [4:0]         cell_x;
  logic [4:0]         cell_y;
  logic [7:0]         cell_value;
  logic [9:0]         column;
  logic [12:0]        pos_x;
  logic [12:0]        pos_y;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] plane_x;
  logic signed [15:0] plane_y;

  modport source (output valid, operation, cell_x, cell_y, cell_value, column,
                  pos_x, pos_y, dir_x, dir_y, plane_x, plane_y, input ready);
  modport sink (input valid, operation, cell_x, cell_y, cell_value, column,
                pos_x, pos_y, dir_x, dir_y, plane_x, plane_y, output ready);
endinterface

interface drc_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] out_column;
  logic [8:0] draw_start;
  logic [8:0] draw_end;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       wall_side;
  logic [7:0] wall_type;
  logic       escaped;

  modport source (output valid, out_column, draw_start, draw_end, red, green, blue,
                  wall_side, wall_type, escaped, input ready);
  modport sink (input valid, out_column, draw_start, draw_end, red, green, blue,
                wall_side, wall_type, escaped, output ready);
endinterface

@@ design/drc_div.sv @@
module drc_div #(
  parameter int NW = drc_pkg::DIV_NW,
  parameter int DW = drc_pkg::DIV_DW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CNT_W = $clog2(NW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NW-1:0]    quo_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    dvs_r;
  logic [DW:0]      trial;
  logic             qbit_nxt;
  logic [DW-1:0]    rem_nxt;

  // one restoring step per cycle, dividend bits shift out as quotient bits shift in
  always_comb begin
    trial    = {rem_r, quo_r[NW-1]};
    qbit_nxt = (trial >= {1'b0, dvs_r});
    rem_nxt  = qbit_nxt ? DW'(trial - {1'b0, dvs_r}) : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-2:0], qbit_nxt};
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ design/drc_map.sv @@
module drc_map #(
  parameter int MAP_SIDE = drc_pkg::MAP_SIDE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  drc_pkg::map_req_t           req,
  output logic [drc_pkg::CELL_W-1:0]  rdata,
  output logic                        busy
);

  localparam int DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int AW    = $clog2(DEPTH);

  logic [drc_pkg::CELL_W-1:0] mem [DEPTH];
  logic [drc_pkg::CELL_W-1:0] rdata_r;
  logic [AW-1:0]              clr_r;
  logic                       clr_act_r;

  // sweep every entry to empty after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_act_r <= 1'b1;
      clr_r     <= '0;
    end else if (clr_act_r) begin
      clr_r <= clr_r + 1'b1;
      if (clr_r == AW'(DEPTH - 1)) begin
        clr_act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_act_r) begin
      mem[clr_r] <= drc_pkg::CELL_EMPTY;
    end else if (req.we) begin
      mem[req.addr[AW-1:0]] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.addr[AW-1:0]];
    end
  end

  assign rdata = rdata_r;
  assign busy  = clr_act_r;

endmodule

@@ design/dda_raycast_column_unit.sv @@
// Channel   Dir  Role
// --------  ---  ------------------------------------------------------------
// in_ch     in   map cell write or column render request (valid/ready)
// out_ch    out  one wall slice per render request (valid/ready)
// cfg_*     in   color register writes, one per cycle, no read-back
//
// A render takes up to six runs of the shared radix-2 divider, plus a map
// read, then a test, for each grid step, plus setup, fog and output. After
// reset the map (MAP_SIDE*MAP_SIDE entries, 1024 by default) is swept clear
// with in_ch.ready low. A finished slice waits in the output register, and
// the next request is taken while it waits.
`include "assert_macros.svh"

module dda_raycast_column_unit #(
  parameter int MAP_SIDE      = drc_pkg::MAP_SIDE_DEF,
  parameter int SCREEN_WIDTH  = drc_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = drc_pkg::SCREEN_HEIGHT_DEF,
  parameter int MAX_STEPS     = drc_pkg::MAX_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  drc_in_if.sink                            in_ch,
  drc_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [drc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [drc_pkg::COLOR_W-1:0]       cfg_data
);

  localparam int NW      = drc_pkg::DIV_NW;
  localparam int DW      = drc_pkg::DIV_DW;
  localparam int CW      = (($clog2(MAP_SIDE) > 5) ? $clog2(MAP_SIDE) : 5) + 2;
  localparam int STEP_W  = $clog2(MAX_STEPS + 1);
  localparam int LH_W    = $clog2(2 * SCREEN_HEIGHT + 1);
  localparam int CAMX_W  = 24;
  localparam int PROD_W  = CAMX_W + 16;
  localparam int RAY_W   = PROD_W - 12;
  localparam int HALF    = SCREEN_HEIGHT / 2;

  // camera scale: floor(mag * 2^14 / width) as (mag * CAMX_M) >> CAMX_SH,
  // exact for any 14-bit magnitude
  localparam int CAMX_L  = $clog2(SCREEN_WIDTH);
  localparam int CAMX_SH = 14 + CAMX_L;
  localparam int CAMX_MW = 30;
  localparam logic [CAMX_MW-1:0] CAMX_M =
    CAMX_MW'(((64'd1 << (28 + CAMX_L)) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_CAMX    = 5'd1;
  localparam logic [4:0] S_RAY     = 5'd2;
  localparam logic [4:0] S_RAY2    = 5'd3;
  localparam logic [4:0] S_DDX_GO  = 5'd4;
  localparam logic [4:0] S_DDX_W   = 5'd5;
  localparam logic [4:0] S_DDY_GO  = 5'd6;
  localparam logic [4:0] S_DDY_W   = 5'd7;
  localparam logic [4:0] S_SIDE    = 5'd8;
  localparam logic [4:0] S_STEP    = 5'd9;
  localparam logic [4:0] S_CHECK   = 5'd10;
  localparam logic [4:0] S_PERP    = 5'd11;
  localparam logic [4:0] S_LH_GO   = 5'd12;
  localparam logic [4:0] S_LH_W    = 5'd13;
  localparam logic [4:0] S_FOG_MUL = 5'd14;
  localparam logic [4:0] S_FOG_GO  = 5'd15;
  localparam logic [4:0] S_FOG_W   = 5'd16;
  localparam logic [4:0] S_SHD_GO  = 5'd17;
  localparam logic [4:0] S_SHD_W   = 5'd18;
  localparam logic [4:0] S_FIN     = 5'd19;

  // configuration
  logic [drc_pkg::COLOR_W-1:0] col_two_r, col_three_r, col_def_r;

  // sequencer and ray state
  logic [4:0]                state_r;
  logic [9:0]                column_r;
  logic [7:0]                fx_r, fy_r;
  logic signed [15:0]        dx_r, dy_r, plx_r, ply_r;
  logic                      camx_neg_r;
  logic [13:0]               cam_mag_r;
  logic signed [CAMX_W-1:0]  camx_r;
  logic signed [PROD_W-1:0]  prodx_r, prody_r;
  logic signed [RAY_W-1:0]   rx_r, ry_r;
  logic [DW-1:0]             ddx_r, ddy_r, sdx_r, sdy_r, perp_r, denom_r;
  logic signed [CW-1:0]      mx_r, my_r;
  logic [STEP_W-1:0]         step_cnt_r;
  logic                      side_r;
  logic                      escaped_r;
  logic [7:0]                cell_r;
  logic [LH_W-1:0]           lh_r;
  logic [47:0]               dsq_r;
  logic [31:0]               fog_q_r;
  logic [1:0]                shd_idx_r;
  logic [7:0]                shd_r [3];

  // output register
  logic       out_valid_r;
  logic [9:0] o_column_r;
  logic [8:0] o_ds_r, o_de_r;
  logic [7:0] o_red_r, o_green_r, o_blue_r, o_type_r;
  logic       o_side_r, o_esc_r;

  // datapath helpers
  logic                  in_acc;
  logic signed [13:0]    cam_off;
  logic [13:0]           cam_mag;
  logic [CAMX_MW+13:0]   camx_prod, camx_full;
  logic [63:0]           fog_prod;
  logic signed [RAY_W-1:0] rx_tz, ry_tz;
  logic [RAY_W-1:0]      ax, ay;
  logic [8:0]            wx, wy;
  logic [DW+8:0]         sdx_prod, sdy_prod;
  logic                  step_x;
  logic signed [CW-1:0]  nmx, nmy;
  logic                  in_bounds;
  logic [23:0]           fog_d;
  logic [23:0]           rgb;
  logic [7:0]            comp;
  logic signed [LH_W+1:0] ds_s, de_s;
  logic [8:0]            ds_o, de_o;
  logic                  fin_load;

  // divider and map hookup
  logic          div_start, div_busy, div_done;
  logic [NW-1:0] div_a, div_q;
  logic [DW-1:0] div_b;
  drc_pkg::map_req_t map_req;
  logic [drc_pkg::CELL_W-1:0] map_rdata;
  logic          map_busy;

  drc_div #(.NW(NW), .DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  drc_map #(.MAP_SIDE(MAP_SIDE)) u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (map_req),
    .rdata (map_rdata),
    .busy  (map_busy)
  );

  assign in_ch.ready = (state_r == S_IDLE) && !map_busy;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // color registers; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_two_r   <= drc_pkg::COLOR_TWO_RST;
      col_three_r <= drc_pkg::COLOR_THREE_RST;
      col_def_r   <= drc_pkg::COLOR_DEFAULT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        drc_pkg::REG_COLOR_TWO:     col_two_r   <= cfg_data;
        drc_pkg::REG_COLOR_THREE:   col_three_r <= cfg_data;
        drc_pkg::REG_COLOR_DEFAULT: col_def_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    // camera offset 2*column - width; its magnitude is scaled by 2^14/width
    cam_off = $signed({3'b000, in_ch.column, 1'b0}) - 14'(SCREEN_WIDTH);
    cam_mag = cam_off[13] ? 14'(-cam_off) : 14'(cam_off);
    camx_prod = cam_mag_r * CAMX_M;
    camx_full = camx_prod >> CAMX_SH;

    // truncate toward zero on the Q2.14 scale-down
    rx_tz = dx_r + RAY_W'(prodx_r >>> 14)
          + RAY_W'((prodx_r < 0 && prodx_r[13:0] != '0) ? 1 : 0);
    ry_tz = dy_r + RAY_W'(prody_r >>> 14)
          + RAY_W'((prody_r < 0 && prody_r[13:0] != '0) ? 1 : 0);
    ax = rx_r[RAY_W-1] ? RAY_W'(-rx_r) : RAY_W'(rx_r);
    ay = ry_r[RAY_W-1] ? RAY_W'(-ry_r) : RAY_W'(ry_r);

    // distance to the first grid line on each axis
    wx = rx_r[RAY_W-1] ? {1'b0, fx_r} : 9'(9'd256 - {1'b0, fx_r});
    wy = ry_r[RAY_W-1] ? {1'b0, fy_r} : 9'(9'd256 - {1'b0, fy_r});
    sdx_prod = wx * ddx_r;
    sdy_prod = wy * ddy_r;

    // one DDA step
    step_x = (sdx_r < sdy_r);
    nmx = mx_r;
    nmy = my_r;
    if (step_x) begin
      nmx = rx_r[RAY_W-1] ? CW'(mx_r - 1) : CW'(mx_r + 1);
    end else begin
      nmy = ry_r[RAY_W-1] ? CW'(my_r - 1) : CW'(my_r + 1);
    end
    in_bounds = (nmx >= 0) && (nmx < CW'(MAP_SIDE)) && (nmy >= 0) && (nmy < CW'(MAP_SIDE));

    fog_d = (perp_r > DW'(drc_pkg::FOG_CAP)) ? drc_pkg::FOG_CAP : perp_r[23:0];
    // divide the scaled square by ten with a reciprocal multiply
    fog_prod = dsq_r[47:16] * drc_pkg::FOG_RECIP;

    // color by wall type, darken y-side walls
    if (cell_r == drc_pkg::CELL_TWO) begin
      rgb = col_two_r;
    end else if (cell_r == drc_pkg::CELL_THREE) begin
      rgb = col_three_r;
    end else begin
      rgb = col_def_r;
    end
    case (shd_idx_r)
      2'd0:    comp = rgb[23:16];
      2'd1:    comp = rgb[15:8];
      default: comp = rgb[7:0];
    endcase
    if (side_r) begin
      comp = comp >> 1;
    end

    // vertical span, clamped to the screen
    ds_s = (LH_W+2)'(HALF) - (LH_W+2)'(lh_r >> 1);
    de_s = (LH_W+2)'(HALF) + (LH_W+2)'(lh_r >> 1);
    if (ds_s < 0) begin
      ds_s = '0;
    end
    if (de_s >= (LH_W+2)'(SCREEN_HEIGHT)) begin
      de_s = (LH_W+2)'(SCREEN_HEIGHT - 1);
    end
    ds_o = ds_s[8:0];
    de_o = de_s[8:0];

    fin_load = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);
  end

  // shared divider operand select
  always_comb begin
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    case (state_r)
      S_DDX_GO: begin
        div_start = (ax != '0);
        div_a     = drc_pkg::ONE_Q30;
        div_b     = DW'(ax);
      end
      S_DDY_GO: begin
        div_start = (ay != '0);
        div_a     = drc_pkg::ONE_Q30;
        div_b     = DW'(ay);
      end
      S_LH_GO: begin
        div_start = (perp_r != '0);
        div_a     = NW'(SCREEN_HEIGHT) << 16;
        div_b     = perp_r;
      end
      S_SHD_GO: begin
        div_start = 1'b1;
        div_a     = NW'({comp, 16'b0});
        div_b     = denom_r;
      end
      default: ;
    endcase
  end

  // map port: cell writes from the input, reads from the stepper
  always_comb begin
    map_req       = '0;
    map_req.wdata = in_ch.cell_value;
    if (state_r == S_STEP) begin
      map_req.re   = (step_cnt_r != STEP_W'(MAX_STEPS)) && in_bounds;
      map_req.addr = drc_pkg::MAP_ADDR_W'($unsigned(nmy)) *
                     drc_pkg::MAP_ADDR_W'(MAP_SIDE) +
                     drc_pkg::MAP_ADDR_W'($unsigned(nmx));
    end else begin
      map_req.we   = in_acc && (in_ch.operation == drc_pkg::OP_WRITE) &&
                     ({4'b0, in_ch.cell_x} < 9'(MAP_SIDE)) &&
                     ({4'b0, in_ch.cell_y} < 9'(MAP_SIDE));
      map_req.addr = drc_pkg::MAP_ADDR_W'(in_ch.cell_y) *
                     drc_pkg::MAP_ADDR_W'(MAP_SIDE) +
                     drc_pkg::MAP_ADDR_W'(in_ch.cell_x);
    end
  end

  // render sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      step_cnt_r <= '0;
      shd_idx_r  <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_ch.operation == drc_pkg::OP_RENDER)) begin
            state_r <= S_CAMX;
          end
        end
        S_CAMX:   state_r <= S_RAY;
        S_RAY:    state_r <= S_RAY2;
        S_RAY2:   state_r <= S_DDX_GO;
        S_DDX_GO: state_r <= (ax != '0) ? S_DDX_W : S_DDY_GO;
        S_DDX_W:  if (div_done) state_r <= S_DDY_GO;
        S_DDY_GO: state_r <= (ay != '0) ? S_DDY_W : S_SIDE;
        S_DDY_W:  if (div_done) state_r <= S_SIDE;
        S_SIDE: begin
          step_cnt_r <= '0;
          state_r    <= S_STEP;
        end
        S_STEP: begin
          if (step_cnt_r == STEP_W'(MAX_STEPS) || !in_bounds) begin
            state_r <= S_FIN;
          end else begin
            step_cnt_r <= step_cnt_r + 1'b1;
            state_r    <= S_CHECK;
          end
        end
        S_CHECK:   state_r <= (map_rdata != drc_pkg::CELL_EMPTY) ? S_PERP : S_STEP;
        S_PERP:    state_r <= S_LH_GO;
        S_LH_GO:   state_r <= (perp_r != '0) ? S_LH_W : S_FOG_MUL;
        S_LH_W:    if (div_done) state_r <= S_FOG_MUL;
        S_FOG_MUL: state_r <= S_FOG_GO;
        S_FOG_GO:  state_r <= S_FOG_W;
        S_FOG_W: begin
          shd_idx_r <= '0;
          state_r   <= S_SHD_GO;
        end
        S_SHD_GO:  state_r <= S_SHD_W;
        S_SHD_W: begin
          if (div_done) begin
            if (shd_idx_r == 2'd2) begin
              state_r <= S_FIN;
            end else begin
              shd_idx_r <= shd_idx_r + 1'b1;
              state_r   <= S_SHD_GO;
            end
          end
        end
        S_FIN:     if (fin_load) state_r <= S_IDLE;
        default:   state_r <= S_IDLE;
      endcase
    end
  end

  // ray datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          column_r   <= in_ch.column;
          fx_r       <= in_ch.pos_x[7:0];
          fy_r       <= in_ch.pos_y[7:0];
          mx_r       <= CW'({1'b0, in_ch.pos_x[12:8]});
          my_r       <= CW'({1'b0, in_ch.pos_y[12:8]});
          dx_r       <= in_ch.dir_x;
          dy_r       <= in_ch.dir_y;
          plx_r      <= in_ch.plane_x;
          ply_r      <= in_ch.plane_y;
          camx_neg_r <= cam_off[13];
          cam_mag_r  <= cam_mag;
          escaped_r  <= 1'b0;
        end
      end
      S_CAMX: begin
        camx_r <= camx_neg_r ? CAMX_W'(-$signed({1'b0, camx_full[CAMX_W-2:0]}))
                             : CAMX_W'($signed({1'b0, camx_full[CAMX_W-2:0]}));
      end
      S_RAY: begin
        prodx_r <= plx_r * camx_r;
        prody_r <= ply_r * camx_r;
      end
      S_RAY2: begin
        rx_r <= rx_tz;
        ry_r <= ry_tz;
      end
      S_DDX_GO: if (ax == '0) ddx_r <= drc_pkg::DIST_INF;
      S_DDX_W:  if (div_done) ddx_r <= DW'(div_q);
      S_DDY_GO: if (ay == '0) ddy_r <= drc_pkg::DIST_INF;
      S_DDY_W:  if (div_done) ddy_r <= DW'(div_q);
      S_SIDE: begin
        sdx_r <= sdx_prod[DW+7:8];
        sdy_r <= sdy_prod[DW+7:8];
      end
      S_STEP: begin
        if (step_cnt_r == STEP_W'(MAX_STEPS)) begin
          escaped_r <= 1'b1;
        end else begin
          // advance the nearer axis
          if (step_x) begin
            sdx_r  <= sdx_r + ddx_r;
            side_r <= 1'b0;
          end else begin
            sdy_r  <= sdy_r + ddy_r;
            side_r <= 1'b1;
          end
          mx_r <= nmx;
          my_r <= nmy;
          if (!in_bounds) begin
            escaped_r <= 1'b1;
          end
        end
      end
      S_CHECK:   cell_r <= map_rdata;
      S_PERP:    perp_r <= side_r ? (sdy_r - ddy_r) : (sdx_r - ddx_r);
      S_LH_GO:   if (perp_r == '0) lh_r <= LH_W'(2 * SCREEN_HEIGHT);
      S_LH_W: begin
        if (div_done) begin
          lh_r <= (div_q > NW'(2 * SCREEN_HEIGHT)) ? LH_W'(2 * SCREEN_HEIGHT)
                                                   : div_q[LH_W-1:0];
        end
      end
      S_FOG_MUL: dsq_r <= fog_d * fog_d;
      S_FOG_GO:  fog_q_r <= 32'(fog_prod >> drc_pkg::FOG_SH);
      S_FOG_W:   denom_r <= DW'(32'h0001_0000) + DW'(fog_q_r);
      S_SHD_W:   if (div_done) shd_r[shd_idx_r] <= div_q[7:0];
      default: ;
    endcase
  end

  // output register; hold until the sink takes the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      o_column_r <= column_r;
      o_esc_r    <= escaped_r;
      if (escaped_r) begin
        o_ds_r    <= '0;
        o_de_r    <= '0;
        o_red_r   <= '0;
        o_green_r <= '0;
        o_blue_r  <= '0;
        o_side_r  <= 1'b0;
        o_type_r  <= '0;
      end else begin
        o_ds_r    <= ds_o;
        o_de_r    <= de_o;
        o_red_r   <= shd_r[0];
        o_green_r <= shd_r[1];
        o_blue_r  <= shd_r[2];
        o_side_r  <= side_r;
        o_type_r  <= cell_r;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_column = o_column_r;
  assign out_ch.draw_start = o_ds_r;
  assign out_ch.draw_end   = o_de_r;
  assign out_ch.red        = o_red_r;
  assign out_ch.green      = o_green_r;
  assign out_ch.blue       = o_blue_r;
  assign out_ch.wall_side  = o_side_r;
  assign out_ch.wall_type  = o_type_r;
  assign out_ch.escaped    = o_esc_r;

  `DRC_ASSERT_NOW(a_no_take_while_clear, map_busy, !in_ch.ready, "request taken during map clear")
  `DRC_ASSERT_NOW(a_div_no_restart, div_start, !div_busy, "divider restarted while busy")
  `DRC_ASSERT_NOW(a_step_bound, 1'b1, step_cnt_r <= STEP_W'(MAX_STEPS), "step count overran")
  `DRC_ASSERT_NOW(a_escaped_blank, out_ch.valid && out_ch.escaped,
                  out_ch.draw_start == '0 && out_ch.wall_type == '0 && out_ch.red == '0,
                  "escaped slice carries wall data")

endmodule

@@ sim/drc_checker.sv @@
`timescale 1ns / 1ps

module drc_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  drc_in_if                             in_ch,
  drc_out_if                            out_ch,
  input  logic                          cfg_we,
  input  logic [drc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [drc_pkg::COLOR_W-1:0]   cfg_data,
  output int                            errors,
  output int                            pending
);

  localparam int MSIDE  = drc_pkg::MAP_SIDE_DEF;
  localparam int SWIDTH = drc_pkg::SCREEN_WIDTH_DEF;
  localparam int SHGT   = drc_pkg::SCREEN_HEIGHT_DEF;

  typedef struct {
    logic [9:0] column;
    logic [8:0] draw_start;
    logic [8:0] draw_end;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       wall_side;
    logic [7:0] wall_type;
    logic       escaped;
  } slice_t;

  logic [drc_pkg::CELL_W-1:0]  grid [MSIDE*MSIDE];
  logic [drc_pkg::COLOR_W-1:0] color_two, color_three, color_other;
  slice_t                      expected_slices [$];

  function automatic longint ray_delta(longint r);
    longint mag;
    mag = (r < 0) ? -r : r;
    return (mag == 0) ? longint'(drc_pkg::DIST_INF) : (longint'(1) << 30) / mag;
  endfunction

  function automatic slice_t cast_column(logic [9:0] col, logic [12:0] px, logic [12:0] py,
                                         logic signed [15:0] dx, logic signed [15:0] dy,
                                         logic signed [15:0] plx, logic signed [15:0] ply);
    longint camx, rx, ry, ddx, ddy, sdx, sdy, perp, lh, d, denom, ds, de;
    int mx, my, stx, sty;
    bit hit, side;
    logic [7:0] hit_type, r, g, b;
    logic [23:0] rgb;
    slice_t res;
    camx = ((2 * longint'(col) - SWIDTH) * 16384) / SWIDTH;
    rx = longint'(dx) + (longint'(plx) * camx) / 16384;
    ry = longint'(dy) + (longint'(ply) * camx) / 16384;
    mx = px[12:8];
    my = py[12:8];
    ddx = ray_delta(rx);
    ddy = ray_delta(ry);
    if (rx < 0) begin
      stx = -1; sdx = (longint'(px[7:0]) * ddx) >> 8;
    end else begin
      stx = 1;  sdx = ((256 - longint'(px[7:0])) * ddx) >> 8;
    end
    if (ry < 0) begin
      sty = -1; sdy = (longint'(py[7:0]) * ddy) >> 8;
    end else begin
      sty = 1;  sdy = ((256 - longint'(py[7:0])) * ddy) >> 8;
    end
    hit = 0; side = 0; hit_type = drc_pkg::CELL_EMPTY;
    for (int s = 0; s < drc_pkg::MAX_STEPS_DEF; s++) begin
      if (sdx < sdy) begin
        sdx += ddx; mx += stx; side = 0;
      end else begin
        sdy += ddy; my += sty; side = 1;
      end
      if (mx < 0 || mx >= MSIDE || my < 0 || my >= MSIDE) break;
      hit_type = grid[my * MSIDE + mx];
      if (hit_type != drc_pkg::CELL_EMPTY) begin
        hit = 1;
        break;
      end
    end
    res = '{col, 0, 0, 0, 0, 0, 0, 0, 1};
    if (!hit) return res;
    perp = side ? sdy - ddy : sdx - ddx;
    lh = (perp == 0) ? 2 * SHGT : (longint'(SHGT) << 16) / perp;
    if (lh > 2 * SHGT) lh = 2 * SHGT;
    ds = SHGT / 2 - lh / 2;
    de = SHGT / 2 + lh / 2;
    if (ds < 0) ds = 0;
    if (de >= SHGT) de = SHGT - 1;
    rgb = (hit_type == drc_pkg::CELL_TWO) ? color_two :
          (hit_type == drc_pkg::CELL_THREE) ? color_three : color_other;
    {r, g, b} = rgb;
    if (side) begin
      r >>= 1; g >>= 1; b >>= 1;
    end
    d = (perp > longint'(drc_pkg::FOG_CAP)) ? longint'(drc_pkg::FOG_CAP) : perp;
    denom = 65536 + ((d * d) >> 16) / 10;
    res.draw_start = ds[8:0];
    res.draw_end   = de[8:0];
    res.red        = 8'((longint'(r) << 16) / denom);
    res.green      = 8'((longint'(g) << 16) / denom);
    res.blue       = 8'((longint'(b) << 16) / denom);
    res.wall_side  = side;
    res.wall_type  = hit_type;
    res.escaped    = 0;
    return res;
  endfunction

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  assign pending = expected_slices.size();

  always @(posedge clk) begin
    slice_t e;
    if (!rst_n) begin
      foreach (grid[i]) grid[i] = drc_pkg::CELL_EMPTY;
      color_two   = drc_pkg::COLOR_TWO_RST;
      color_three = drc_pkg::COLOR_THREE_RST;
      color_other = drc_pkg::COLOR_DEFAULT_RST;
      expected_slices.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          drc_pkg::REG_COLOR_TWO:     color_two   = cfg_data;
          drc_pkg::REG_COLOR_THREE:   color_three = cfg_data;
          drc_pkg::REG_COLOR_DEFAULT: color_other = cfg_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.operation == drc_pkg::OP_WRITE)
          grid[in_ch.cell_y * MSIDE + in_ch.cell_x] = in_ch.cell_value;
        else
          expected_slices.push_back(cast_column(in_ch.column, in_ch.pos_x, in_ch.pos_y,
                                                in_ch.dir_x, in_ch.dir_y,
                                                in_ch.plane_x, in_ch.plane_y));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_slices.size() == 0) begin
          $error("unexpected slice for column %0d", out_ch.out_column);
          errors++;
        end else begin
          e = expected_slices.pop_front();
          check_field("out_column", e.column, out_ch.out_column);
          check_field("draw_start", e.draw_start, out_ch.draw_start);
          check_field("draw_end", e.draw_end, out_ch.draw_end);
          check_field("red", e.red, out_ch.red);
          check_field("green", e.green, out_ch.green);
          check_field("blue", e.blue, out_ch.blue);
          check_field("wall_side", e.wall_side, out_ch.wall_side);
          check_field("wall_type", e.wall_type, out_ch.wall_type);
          check_field("escaped", e.escaped, out_ch.escaped);
        end
      end
    end
  end

endmodule

@@ sim/tb_dda_raycast_column_unit.sv @@
`timescale 1ns / 1ps

module tb_dda_raycast_column_unit;

  // Index 3 maps to no register; writes there must be dropped.
  localparam logic [drc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [drc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [drc_pkg::COLOR_W-1:0]   cfg_data = '0;
  int                            errors;
  int                            pending;
  int                            sent = 0;
  int                            burst_left = 0;

  drc_in_if  in_if ();
  drc_out_if out_if ();

  dda_raycast_column_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if.sink),
    .out_ch    (out_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  drc_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: cycle through random stall modes. Once, after 200
  // transfers in, hold ready low long enough for a render to finish, park in
  // the output register, and back up the input side.
  int  mode_cycles = 0;
  int  stall_mode  = 0;
  int  hold_left   = 0;
  bit  hold_done   = 0;

  always @(posedge clk) begin
    if (mode_cycles == 0) begin
      stall_mode  <= $urandom_range(0, 2);
      mode_cycles <= 200;
    end else begin
      mode_cycles <= mode_cycles - 1;
    end
    if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (!hold_done && sent >= 200) begin
      hold_done    <= 1'b1;
      hold_left    <= 1500;
      out_if.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= 1'($urandom_range(0, 1));
        default: out_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Offer one item and hold it until the transfer. Insert a random gap at the
  // end of each burst so idle cycles land on every phase of a render.
  task automatic send_item(logic op, logic [4:0] cx, logic [4:0] cy, logic [7:0] cv,
                           logic [9:0] col, logic [12:0] px, logic [12:0] py,
                           logic signed [15:0] dx, logic signed [15:0] dy,
                           logic signed [15:0] plx, logic signed [15:0] ply);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid      <= 1'b1;
    in_if.operation  <= op;
    in_if.cell_x     <= cx;
    in_if.cell_y     <= cy;
    in_if.cell_value <= cv;
    in_if.column     <= col;
    in_if.pos_x      <= px;
    in_if.pos_y      <= py;
    in_if.dir_x      <= dx;
    in_if.dir_y      <= dy;
    in_if.plane_x    <= plx;
    in_if.plane_y    <= ply;
    do @(posedge clk); while (!in_if.ready);
    sent++;
  endtask

  // Unused fields carry noise; the block must ignore them.
  task automatic put_cell(logic [4:0] cx, logic [4:0] cy, logic [7:0] cv);
    send_item(drc_pkg::OP_WRITE, cx, cy, cv, 10'($urandom), 13'($urandom), 13'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic render(logic [9:0] col, logic [12:0] px, logic [12:0] py,
                        logic signed [15:0] dx, logic signed [15:0] dy,
                        logic signed [15:0] plx, logic signed [15:0] ply);
    send_item(drc_pkg::OP_RENDER, 5'($urandom), 5'($urandom), 8'($urandom),
              col, px, py, dx, dy, plx, ply);
  endtask

  // Drop valid, let every slice drain, then allow a trailing cell write to
  // retire before touching the color registers.
  task automatic drain();
    in_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [drc_pkg::CFG_IDX_W-1:0] idx,
                           logic [drc_pkg::COLOR_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random traffic: about 40% cell writes, the rest renders from inside the
  // map with moderate vectors; a tenth of renders use unconstrained fields.
  task automatic random_phase(int count);
    logic [7:0] cv;
    repeat (count) begin
      if ($urandom_range(0, 9) < 4) begin
        cv = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
        put_cell(5'($urandom), 5'($urandom), cv);
      end else if ($urandom_range(0, 9) == 0) begin
        render(10'($urandom), 13'($urandom), 13'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 16'($urandom));
      end else begin
        render(10'($urandom_range(0, 1023)),
               {5'($urandom_range(1, 30)), 8'($urandom)},
               {5'($urandom_range(1, 30)), 8'($urandom)},
               16'($signed($urandom_range(0, 32768)) - 16384),
               16'($signed($urandom_range(0, 32768)) - 16384),
               16'($signed($urandom_range(0, 24000)) - 12000),
               16'($signed($urandom_range(0, 24000)) - 12000));
      end
    end
  endtask

  initial begin
    in_if.valid      = 1'b0;
    in_if.operation  = drc_pkg::OP_WRITE;
    in_if.cell_x     = '0;
    in_if.cell_y     = '0;
    in_if.cell_value = '0;
    in_if.column     = '0;
    in_if.pos_x      = '0;
    in_if.pos_y      = '0;
    in_if.dir_x      = '0;
    in_if.dir_y      = '0;
    in_if.plane_x    = '0;
    in_if.plane_y    = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Empty map: every ray leaves the grid.
    render(10'd400, 13'h1080, 13'h1080, 16'sd16384, 16'sd0, 16'sd0, 16'sd10813);
    // Walls on four sides of the center cell, of types two, three, other.
    put_cell(5'd20, 5'd16, drc_pkg::CELL_TWO);
    put_cell(5'd16, 5'd20, drc_pkg::CELL_THREE);
    put_cell(5'd10, 5'd16, 8'd255);
    put_cell(5'd16, 5'd10, 8'd1);
    put_cell(5'd16, 5'd15, 8'd7);
    render(10'd400, 13'h1080, 13'h1080, 16'sd16384, 16'sd0, 16'sd0, 16'sd10813);
    render(10'd0, 13'h1080, 13'h1080, -16'sd16384, 16'sd0, 16'sd0, -16'sd10813);
    render(10'd799, 13'h1080, 13'h1080, 16'sd0, 16'sd16384, -16'sd10813, 16'sd0);
    // Column past the screen edge.
    render(10'd1023, 13'h1080, 13'h1080, 16'sd0, -16'sd16384, 16'sd10813, 16'sd0);
    // Zero ray: both deltas infinite, the tie steps along y.
    render(10'd400, 13'h1080, 13'h1080, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    // Zero distance: start on a cell boundary, looking into the wall behind it.
    render(10'd400, 13'h1080, 13'h1000, 16'sd0, -16'sd16384, 16'sd0, 16'sd0);
    // Vector extremes and position extremes.
    render(10'd0, 13'h1080, 13'h1080, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
    render(10'd799, 13'h1FFF, 13'h0000, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
    render(10'd512, 13'h0000, 13'h1FFF, 16'sh7FFF, 16'sh7FFF, 16'sh0000, 16'sh0000);
    render(10'd300, 13'h1080, 13'h1080, 16'sd3000, 16'sd16000, 16'sd0, 16'sd0);
    random_phase(150);

    drain();
    write_reg(drc_pkg::REG_COLOR_TWO, 24'h000000);
    write_reg(drc_pkg::REG_COLOR_THREE, 24'h000000);
    write_reg(drc_pkg::REG_COLOR_DEFAULT, 24'h000000);
    random_phase(155);

    drain();
    write_reg(drc_pkg::REG_COLOR_TWO, 24'hFFFFFF);
    write_reg(drc_pkg::REG_COLOR_THREE, 24'hFFFFFF);
    write_reg(drc_pkg::REG_COLOR_DEFAULT, 24'hFFFFFF);
    write_reg(REG_UNMAPPED, 24'h123456);
    random_phase(155);

    drain();
    write_reg(drc_pkg::REG_COLOR_TWO, 24'($urandom));
    write_reg(drc_pkg::REG_COLOR_THREE, 24'($urandom));
    write_reg(drc_pkg::REG_COLOR_DEFAULT, 24'($urandom));
    write_reg(REG_UNMAPPED, 24'($urandom));
    random_phase(155);

    // Wait out the last slices, then a render's worth of quiet cycles.
    drain();
    repeat (500) @(posedge clk);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/drc_pkg.sv
design/drc_if.sv
design/drc_div.sv
design/drc_map.sv
design/dda_raycast_column_unit.sv
sim/drc_checker.sv
sim/tb_dda_raycast_column_unit.sv
